// ----- rtl/pfps_pkg.sv -----
// package: constants, types and helper functions for the fuzzy prefix scanner
package pfps_pkg;
	localparam int TableDepth = 512;
	localparam int KeyLetters = 8;
	localparam int ResultBufferBytes = 256;
	localparam int MaxCodes = (ResultBufferBytes - 2) / 3;
	localparam int AddrW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int NcW = $clog2(MaxCodes + 1);
	localparam int PosW = 4;

	localparam logic [1:0] ModeClear = 2'd0;
	localparam logic [1:0] ModeAppend = 2'd1;
	localparam logic [1:0] ModeQuery = 2'd2;

	localparam logic [7:0] ChH = 8'h68;
	localparam logic [7:0] ChG = 8'h67;
	localparam logic [7:0] ChN = 8'h6e;
	localparam logic [7:0] ChL = 8'h6c;
	localparam logic [7:0] ChV = 8'h76;

	typedef struct packed {
		logic start;
		logic [63:0] q;
		logic [63:0] t;
	} match_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} match_rsp_t;

	function automatic logic [7:0] key_char(input logic [63:0] k, input logic [PosW-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < PosW'(KeyLetters))
			c = k[8*(7-pos[2:0]) +: 8];
		return c;
	endfunction

	function automatic logic is_vowel(input logic [7:0] c);
		return c == 8'h61 || c == 8'h65 || c == 8'h69 || c == 8'h6f || c == 8'h75 || c == ChV;
	endfunction

	function automatic logic is_sib(input logic [7:0] c);
		return c == 8'h7a || c == 8'h63 || c == 8'h73;
	endfunction
endpackage

// ----- rtl/pinyin_fuzzy_prefix_scan.sv -----
// top level: entry table, scan sequencer and result register
// Items enter on in_valid/in_ready with mode, key and entry_code; results
// leave on out_valid/out_ready with found, code_first, code_second,
// pair_count and last.
// Clear and append give no result and leave the scanner idle for the next item.
// A query reads entries in append order, one table read then one fuzzy
// match; the shared matcher walks the letters of both keys step by step and
// takes one entry at a time; in_ready stays low while the query runs.
// A pair of codes is sent once a further code is found, the final one or two
// codes go out with last set; while the receiver stalls a full result the
// scan waits on it, nothing is dropped.
// The scan stops after 84 codes. Empty key or no code gives one result
// with found 0 and last 1.
// Reset empties the table (entry count to zero) and idles both channels;
// table contents need no clearing pass.
module pinyin_fuzzy_prefix_scan import pfps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [63:0] key,
	input  logic [23:0] entry_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [23:0] code_first,
	output logic [23:0] code_second,
	output logic [1:0]  pair_count,
	output logic        last
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_WAIT  = 6'b000100,
		S_MATCH = 6'b001000,
		S_EMIT  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	logic [63:0] key_mem [TableDepth];
	logic [23:0] code_mem [TableDepth];
	logic [63:0] rd_key_q;
	logic [23:0] rd_code_q;
	logic [CntW-1:0] cnt_q, n_q;
	logic [NcW-1:0] nc_q;
	logic [63:0] qkey_q;
	logic [23:0] hold_q;
	logic [23:0] hold2_q;
	logic [1:0] hold_n_q;
	match_req_t mreq;
	match_rsp_t mrsp;
	logic out_free;
	logic emit_now;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;
	assign emit_now = ((state_q == S_EMIT) || (state_q == S_FIN)) && out_free;
	assign mreq.start = (state_q == S_WAIT);
	assign mreq.q = qkey_q;
	assign mreq.t = rd_key_q;

	pfps_match u_match (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && mode == ModeAppend && cnt_q < CntW'(TableDepth)) begin
			key_mem[cnt_q[AddrW-1:0]] <= key;
			code_mem[cnt_q[AddrW-1:0]] <= entry_code;
		end
		rd_key_q <= key_mem[n_q[AddrW-1:0]];
		rd_code_q <= code_mem[n_q[AddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			n_q <= '0;
			nc_q <= '0;
			hold_n_q <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (emit_now)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= '0;
						nc_q <= '0;
						hold_n_q <= 2'd0;
						qkey_q <= key;
						case (mode)
							ModeClear: cnt_q <= '0;
							ModeAppend: if (cnt_q < CntW'(TableDepth)) cnt_q <= cnt_q + CntW'(1);
							ModeQuery: state_q <= (key[63:56] == 8'h00) ? S_FIN : S_READ;
							default: ;
						endcase
					end
				end
				S_READ: state_q <= (n_q < cnt_q) ? S_WAIT : S_FIN;
				S_WAIT: state_q <= S_MATCH;
				S_MATCH: begin
					if (mrsp.done) begin
						if (mrsp.hit && rd_code_q != 24'h0) begin
							if (nc_q >= NcW'(MaxCodes)) begin
								state_q <= S_FIN;
							end else begin
								nc_q <= nc_q + NcW'(1);
								if (hold_n_q == 2'd2) begin
									state_q <= S_EMIT;
								end else begin
									n_q <= n_q + CntW'(1);
									if (hold_n_q == 2'd0)
										hold_q <= rd_code_q;
									else
										hold2_q <= rd_code_q;
									hold_n_q <= hold_n_q + 2'd1;
									state_q <= S_READ;
								end
							end
						end else begin
							n_q <= n_q + CntW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						found <= 1'b1;
						code_first <= hold_q;
						code_second <= hold2_q;
						pair_count <= 2'd2;
						last <= 1'b0;
						hold_q <= rd_code_q;
						hold_n_q <= 2'd1;
						n_q <= n_q + CntW'(1);
						state_q <= S_READ;
					end
				end
				S_FIN: begin
					if (out_free) begin
						found <= hold_n_q != 2'd0;
						code_first <= (hold_n_q != 2'd0) ? hold_q : 24'h0;
						code_second <= (hold_n_q == 2'd2) ? hold2_q : 24'h0;
						pair_count <= hold_n_q;
						last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid);
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> pair_count != 2'd0)
		else $error("found result without codes");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({found, code_first, code_second, pair_count, last}))
		else $error("result changed while waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MATCH) |-> n_q < cnt_q)
		else $error("scan past entry count");
endmodule

// ----- rtl/pfps_match.sv -----
// iterative fuzzy matcher: one letter step of both keys per cycle
module pfps_match import pfps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  match_req_t req,
	output match_rsp_t rsp
);
	logic [PosW-1:0] i_q, j_q;
	logic [63:0] q_q, t_q;
	logic vs_q, busy_q;
	logic [7:0] a, b, a1, b1;
	logic vs, stop, fail;
	logic [PosW-1:0] ni, nj;

	always_comb begin
		a = key_char(q_q, i_q);
		b = key_char(t_q, j_q);
		a1 = key_char(q_q, i_q + PosW'(1));
		b1 = key_char(t_q, j_q + PosW'(1));
		vs = vs_q | is_vowel(a);
		stop = (a == 8'h00) || (b == 8'h00);
		fail = 1'b0;
		ni = i_q + PosW'(1);
		nj = j_q + PosW'(1);
		if (is_sib(a) && is_sib(b)) begin
			fail = a != b;
			ni = i_q + ((a1 == ChH) ? PosW'(2) : PosW'(1));
			nj = j_q + ((b1 == ChH) ? PosW'(2) : PosW'(1));
		end else if (!vs && (a == ChN || a == ChL) && (b == ChN || b == ChL)) begin
		end else if (vs && a == ChN && b == ChN) begin
			ni = i_q + ((a1 == ChG) ? PosW'(2) : PosW'(1));
			nj = j_q + ((b1 == ChG) ? PosW'(2) : PosW'(1));
		end else begin
			fail = a != b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp <= '0;
		end else begin
			rsp.done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (stop || fail) begin
					busy_q <= 1'b0;
					rsp.done <= 1'b1;
					rsp.hit <= stop && (a == 8'h00);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.q;
			t_q <= req.t;
			i_q <= '0;
			j_q <= '0;
			vs_q <= 1'b0;
		end else if (busy_q && !stop) begin
			i_q <= ni;
			j_q <= nj;
			vs_q <= vs;
		end
	end
endmodule

// ----- dv/tb_top.sv -----
// testbench for the fuzzy pinyin prefix scanner: directed and random items, scoreboard check
module tb_top;
	import pfps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        found;
		logic [23:0] code_first;
		logic [23:0] code_second;
		logic [1:0]  pair_count;
		logic        last;
	} scan_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = ModeClear;
	logic [63:0] key = '0;
	logic [23:0] entry_code = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        found;
	logic [23:0] code_first;
	logic [23:0] code_second;
	logic [1:0]  pair_count;
	logic        last;

	localparam logic [1:0] ModeSpare = 2'd3;
	localparam int WatchLimit = 200000;

	logic [63:0] tbl_key[TableDepth];
	logic [23:0] tbl_code[TableDepth];
	int          tbl_count;
	scan_res_t   expected_q[$];
	int          send_idle_pct, recv_idle_pct;
	int          mismatches, results_seen, items_sent, queries_sent, stall;
	string       syl_pool[24];

	pinyin_fuzzy_prefix_scan u_dut (.*);

	always #4 clk = ~clk;

	function automatic logic [63:0] pack_key(string s);
		logic [63:0] k;
		k = '0;
		for (int n = 0; n < s.len() && n < 8; n++)
			k[8*(7-n) +: 8] = s[n];
		return k;
	endfunction

	function automatic logic [7:0] letter_at(logic [63:0] k, int pos);
		if (pos >= KeyLetters || pos > 7)
			return 8'h00;
		return k[8*(7-pos) +: 8];
	endfunction

	function automatic bit vowel(logic [7:0] c);
		return c == "a" || c == "e" || c == "i" || c == "o" || c == "u" || c == "v";
	endfunction

	function automatic bit sibilant(logic [7:0] c);
		return c == "z" || c == "c" || c == "s";
	endfunction

	function automatic bit fuzzy_prefix(logic [63:0] q, logic [63:0] t);
		int i, j;
		bit seen;
		logic [7:0] a, b;
		i = 0;
		j = 0;
		seen = 0;
		while (letter_at(q, i) != 0 && letter_at(t, j) != 0) begin
			a = letter_at(q, i);
			b = letter_at(t, j);
			if (vowel(a))
				seen = 1;
			if (sibilant(a) && sibilant(b)) begin
				if (a != b)
					return 0;
				i += (letter_at(q, i + 1) == ChH) ? 2 : 1;
				j += (letter_at(t, j + 1) == ChH) ? 2 : 1;
			end else if (!seen && (a == ChN || a == ChL) && (b == ChN || b == ChL)) begin
				i++;
				j++;
			end else if (seen && a == ChN && b == ChN) begin
				i += (letter_at(q, i + 1) == ChG) ? 2 : 1;
				j += (letter_at(t, j + 1) == ChG) ? 2 : 1;
			end else begin
				if (a != b)
					return 0;
				i++;
				j++;
			end
		end
		return letter_at(q, i) == 0;
	endfunction

	task automatic predict_scan(logic [1:0] m, logic [63:0] k, logic [23:0] c);
		logic [23:0] hits[$];
		scan_res_t r;
		if (m == ModeClear) begin
			tbl_count = 0;
		end else if (m == ModeAppend) begin
			if (tbl_count < TableDepth) begin
				tbl_key[tbl_count] = k;
				tbl_code[tbl_count] = c;
				tbl_count++;
			end
		end else if (m == ModeQuery) begin
			queries_sent++;
			if (letter_at(k, 0) != 0)
				for (int n = 0; n < tbl_count; n++) begin
					if (!fuzzy_prefix(k, tbl_key[n]) || tbl_code[n] == 0)
						continue;
					if (hits.size() >= MaxCodes)
						break;
					hits.push_back(tbl_code[n]);
				end
			if (hits.size() == 0) begin
				r = '{1'b0, 24'd0, 24'd0, 2'd0, 1'b1};
				expected_q.push_back(r);
			end
			for (int p = 0; p < hits.size(); p += 2) begin
				r.found = 1'b1;
				r.code_first = hits[p];
				r.code_second = (p + 1 < hits.size()) ? hits[p+1] : 24'd0;
				r.pair_count = (p + 1 < hits.size()) ? 2'd2 : 2'd1;
				r.last = (p + 2 >= hits.size());
				expected_q.push_back(r);
			end
		end
	endtask

	task automatic send_item(logic [1:0] m, logic [63:0] k, logic [23:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		predict_scan(m, k, c);
		in_valid <= 1'b1;
		mode <= m;
		key <= k;
		entry_code <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	always @(posedge clk)
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		scan_res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = '{found, code_first, code_second, pair_count, last};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall <= 0;
		else
			stall <= stall + 1;
		if (stall > WatchLimit) begin
			$display("watchdog: no progress");
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [63:0] rand_syllable();
		logic [63:0] k;
		k = pack_key(syl_pool[$urandom_range(23)]);
		if ($urandom_range(3) == 0)
			k = k & ~(64'hFFFFFFFFFFFFFFFF >> (8 * $urandom_range(1, 7)));
		return k;
	endfunction

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(ModeQuery, pack_key("zhang"), 24'd0);
		send_item(ModeQuery, 64'd0, 24'd0);
		send_item(ModeAppend, pack_key("zhang"), 24'hFFFFFF);
		send_item(ModeAppend, pack_key("zang"), 24'h000001);
		send_item(ModeAppend, pack_key("nong"), 24'd0);
		send_item(ModeAppend, pack_key("long"), 24'h123456);
		send_item(ModeAppend, pack_key("lin"), 24'hABCDEF);
		send_item(ModeAppend, pack_key("shi"), 24'h800000);
		send_item(ModeAppend, pack_key("chuang"), 24'h0F0F0F);
		send_item(ModeAppend, 64'hFFFFFFFFFFFFFFFF, 24'h555555);
		send_item(ModeSpare, pack_key("zhang"), 24'h777777);
		send_item(ModeQuery, pack_key("z"), 24'd0);
		send_item(ModeQuery, pack_key("zan"), 24'd0);
		send_item(ModeQuery, pack_key("non"), 24'd0);
		send_item(ModeQuery, pack_key("ling"), 24'd0);
		send_item(ModeQuery, pack_key("si"), 24'd0);
		send_item(ModeQuery, pack_key("cuan"), 24'd0);
		send_item(ModeQuery, 64'hFFFFFFFFFFFFFFFF, 24'd0);
		send_item(ModeQuery, pack_key("qqq"), 24'd0);
		send_item(ModeClear, 64'd0, 24'd0);
		send_item(ModeQuery, pack_key("z"), 24'd0);
		wait_drain();
	endtask

	task automatic test_limits();
		// long table, then a query hitting the code limit
		send_item(ModeClear, 64'd0, 24'd0);
		for (int n = 0; n < 90; n++)
			send_item(ModeAppend, pack_key((n < 86) ? "ba" : "mo"),
				24'($urandom_range(1, 24'hFFFFFF)));
		send_item(ModeQuery, pack_key("b"), 24'd0);
		send_item(ModeAppend, pack_key("ba"), 24'h111111);
		send_item(ModeQuery, pack_key("m"), 24'd0);
		send_item(ModeClear, 64'd0, 24'd0);
		wait_drain();
	endtask

	task automatic test_random(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 3)
				send_item(ModeClear, {$urandom, $urandom}, 24'($urandom));
			else if (pick < 50)
				send_item(ModeAppend, rand_syllable(),
					($urandom_range(7) == 0) ? 24'd0 : 24'($urandom));
			else if (pick < 90)
				send_item(ModeQuery, rand_syllable(), 24'($urandom));
			else if (pick < 95)
				send_item(ModeQuery, {$urandom, $urandom}, 24'($urandom));
			else
				send_item(($urandom_range(1)) ? ModeSpare : ModeAppend,
					{$urandom, $urandom}, 24'($urandom));
		end
		wait_drain();
	endtask

	initial begin
		syl_pool = '{"zhang", "zang", "chuan", "cuan", "shi", "si", "nong", "long",
			"lan", "nan", "ning", "lin", "xiang", "xian", "zhong", "zong",
			"shen", "sheng", "lv", "nv", "ma", "zhuang", "chong", "a"};
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_limits();
		send_idle_pct = 24;
		recv_idle_pct = 84;
		test_random(80);
		send_idle_pct = 84;
		recv_idle_pct = 24;
		test_random(75);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(80);
		$display("covered %0d items, %0d queries, %0d results checked", items_sent,
			queries_sent, results_seen);
		$display("code limit, fuzzy rules, odd and even code counts and idle patterns exercised");
		if (mismatches == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/pfps_pkg.sv
rtl/pfps_match.sv
rtl/pinyin_fuzzy_prefix_scan.sv
dv/tb_top.sv
